FILE: design/cfblr_pkg.sv
// ============================================================================
// cfblr_pkg
// Shared types and constants for the box crop, flip and label remap block.
// ============================================================================
package cfblr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = FRAC_BITS + 1;
    localparam int CLASS_W    = 10;
    localparam int LIMIT_W    = 11;
    localparam int DIM_W      = 14;
    localparam int START_W    = 13;
    localparam int EXT_W      = 15;
    localparam int QUOT_W     = FRAC_BITS;
    localparam int REM_W      = 16;
    localparam int DIV_STAGES = QUOT_W;
    localparam int LANES      = 4;
    localparam int PROD_W     = 35;
    localparam int POS_W      = 19;
    localparam int ASP_W      = 2 * COORD_W;

    // Status codes.
    localparam logic [2:0] ST_KEPT       = 3'd0;
    localparam logic [2:0] ST_CLASS      = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE = 3'd2;
    localparam logic [2:0] ST_CROPPED    = 3'd3;
    localparam logic [2:0] ST_ASPECT     = 3'd4;

    // Orientation modes.
    localparam logic [2:0] OR_NONE  = 3'd0;
    localparam logic [2:0] OR_LEFT  = 3'd1;
    localparam logic [2:0] OR_RIGHT = 3'd2;
    localparam logic [2:0] OR_HFLIP = 3'd3;
    localparam logic [2:0] OR_VFLIP = 3'd4;
    localparam logic [2:0] OR_R180  = 3'd5;

    // Register indexes.
    localparam logic [2:0] RG_SRC_W   = 3'd0;
    localparam logic [2:0] RG_SRC_H   = 3'd1;
    localparam logic [2:0] RG_WIN_L   = 3'd2;
    localparam logic [2:0] RG_WIN_T   = 3'd3;
    localparam logic [2:0] RG_WIN_R   = 3'd4;
    localparam logic [2:0] RG_WIN_B   = 3'd5;
    localparam logic [2:0] RG_ORIENT  = 3'd6;
    localparam logic [2:0] RG_CLS_LIM = 3'd7;

    localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_BITS;

    // Item data carried along the pipeline.
    typedef struct packed {
        logic [2:0]         st;
        logic [CLASS_W-1:0] cls;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic               cx;
        logic               cy;
        logic               complete;
    } item_t;

    // One cropped axis before the divide.
    typedef struct packed {
        logic             fail;
        logic [REM_W-1:0] dsz;
        logic [REM_W-1:0] dctr;
    } axis_t;

    // Mirror about 1.0, saturating at zero.
    function automatic logic [COORD_W-1:0] mirror(input logic [COORD_W-1:0] v);
        mirror = (v > ONE_Q) ? '0 : ONE_Q - v;
    endfunction

endpackage

FILE: design/crop_flip_box_label_remap.sv
// ============================================================================
// crop_flip_box_label_remap
// Crops one box label to a window, checks its class and aspect and applies a rotate or flip mode.
// ============================================================================
//  channel   signals                                   direction
//  label     start, busy, label_class .. line_complete in, accepted on start & !busy
//  result    result_valid, status .. out_h             out, one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata,     APB slave, pready tied high
//            prdata, pready
//
// A new item may be accepted in every cycle; busy is always low.
// Each result passes through the multiply and clamp stages, the 16 stages of the
// one-bit-per-stage restoring dividers, and then the aspect and output stages.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module crop_flip_box_label_remap
    import cfblr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CLASS_W-1:0]  label_class,
    input  logic [COORD_W-1:0]  center_x,
    input  logic [COORD_W-1:0]  center_y,
    input  logic [COORD_W-1:0]  box_width,
    input  logic [COORD_W-1:0]  box_height,
    input  logic                line_complete,
    output logic                result_valid,
    output logic [2:0]          status,
    output logic [CLASS_W-1:0]  out_class,
    output logic [COORD_W-1:0]  out_x,
    output logic [COORD_W-1:0]  out_y,
    output logic [COORD_W-1:0]  out_w,
    output logic [COORD_W-1:0]  out_h,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration registers.
    logic [DIM_W-1:0]   src_w_reg, src_h_reg, win_r_reg, win_b_reg;
    logic [START_W-1:0] win_l_reg, win_t_reg;
    logic [2:0]         orient_reg;
    logic [LIMIT_W-1:0] cls_lim_reg;

    logic signed [EXT_W-1:0] ext_x, ext_y;
    logic                    crop_x, crop_y;
    logic [REM_W-1:0]        divisor [LANES];

    // Pipeline registers.
    logic                        v1_reg;
    item_t                       it1_reg;
    logic signed [PROD_W-1:0]    pxl_reg, pxh_reg, pyl_reg, pyh_reg;

    logic [DIV_STAGES:0]         dv_reg;
    item_t                       dit_reg [DIV_STAGES+1];
    logic [REM_W-1:0]            rem_reg [DIV_STAGES+1][LANES];
    logic [QUOT_W-1:0]           quo_reg [DIV_STAGES+1][LANES];

    logic                        vm_reg;
    item_t                       itm_reg;
    logic [COORD_W-1:0]          nx_reg, ny_reg, nw_reg, nh_reg;
    logic [ASP_W-1:0]            pa_reg, pb_reg;

    // Stage one combinational values.
    logic signed [POS_W:0]       ax, bx, ay, by;
    item_t                       it0;
    // Stage two combinational values.
    axis_t                       axx, axy;
    logic [2:0]                  st2;
    // Aspect stage inputs.
    logic [COORD_W-1:0]          nx, ny, nw, nh;
    item_t                       itd;
    // Output stage values.
    logic [2:0]                  st_o;
    logic                        wr_en;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg   <= DIM_W'(640);
            src_h_reg   <= DIM_W'(480);
            win_l_reg   <= '0;
            win_t_reg   <= '0;
            win_r_reg   <= DIM_W'(640);
            win_b_reg   <= DIM_W'(480);
            orient_reg  <= OR_NONE;
            cls_lim_reg <= LIMIT_W'(80);
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                RG_SRC_W:   src_w_reg   <= pwdata[DIM_W-1:0];
                RG_SRC_H:   src_h_reg   <= pwdata[DIM_W-1:0];
                RG_WIN_L:   win_l_reg   <= pwdata[START_W-1:0];
                RG_WIN_T:   win_t_reg   <= pwdata[START_W-1:0];
                RG_WIN_R:   win_r_reg   <= pwdata[DIM_W-1:0];
                RG_WIN_B:   win_b_reg   <= pwdata[DIM_W-1:0];
                RG_ORIENT:  orient_reg  <= pwdata[2:0];
                RG_CLS_LIM: cls_lim_reg <= pwdata[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (paddr[4:2])
            RG_SRC_W:   prdata = 32'(src_w_reg);
            RG_SRC_H:   prdata = 32'(src_h_reg);
            RG_WIN_L:   prdata = 32'(win_l_reg);
            RG_WIN_T:   prdata = 32'(win_t_reg);
            RG_WIN_R:   prdata = 32'(win_r_reg);
            RG_WIN_B:   prdata = 32'(win_b_reg);
            RG_ORIENT:  prdata = 32'(orient_reg);
            RG_CLS_LIM: prdata = 32'(cls_lim_reg);
            default:    prdata = '0;
        endcase
    end

    // Window extents; the user must hold them steady while items are in flight, the block does not enforce it.
    always_comb
    begin
        ext_x      = $signed({1'b0, win_r_reg}) - $signed({2'b0, win_l_reg});
        ext_y      = $signed({1'b0, win_b_reg}) - $signed({2'b0, win_t_reg});
        crop_x     = ext_x != $signed({1'b0, src_w_reg});
        crop_y     = ext_y != $signed({1'b0, src_h_reg});
        divisor[0] = REM_W'(ext_x);
        divisor[1] = {ext_x, 1'b0};
        divisor[2] = REM_W'(ext_y);
        divisor[3] = {ext_y, 1'b0};
    end

    // Stage one: box edges times the source dimension.
    always_comb
    begin
        ax = $signed({2'b0, center_x, 1'b0}) - $signed({3'b0, box_width});
        bx = $signed({2'b0, center_x, 1'b0}) + $signed({3'b0, box_width});
        ay = $signed({2'b0, center_y, 1'b0}) - $signed({3'b0, box_height});
        by = $signed({2'b0, center_y, 1'b0}) + $signed({3'b0, box_height});
        it0.st       = ST_KEPT;
        it0.cls      = label_class;
        it0.x        = center_x;
        it0.y        = center_y;
        it0.w        = box_width;
        it0.h        = box_height;
        it0.cx       = crop_x;
        it0.cy       = crop_y;
        it0.complete = line_complete;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        it1_reg <= it0;
        pxl_reg <= ax * $signed({1'b0, src_w_reg});
        pxh_reg <= bx * $signed({1'b0, src_w_reg});
        pyl_reg <= ay * $signed({1'b0, src_h_reg});
        pyh_reg <= by * $signed({1'b0, src_h_reg});
    end

    // Pixel span of one axis, clamped to the window.
    function automatic axis_t crop_axis(input logic signed [PROD_W-1:0] plo,
                                        input logic signed [PROD_W-1:0] phi,
                                        input logic [START_W-1:0]       st,
                                        input logic signed [EXT_W-1:0]  ext);
        logic signed [POS_W-1:0] lo, hi, e, hic, loc, dif, sum;
        axis_t r;
        lo  = POS_W'(plo >>> (FRAC_BITS + 1)) - $signed({6'b0, st});
        hi  = POS_W'(phi >>> (FRAC_BITS + 1)) - $signed({6'b0, st});
        e   = POS_W'(ext);
        hic = (hi >= e) ? e - POS_W'(1) : hi;
        loc = (lo < 0) ? '0 : lo;
        dif = hic - loc;
        sum = hic + loc;
        r.fail = (hi < POS_W'(1)) || (hic < loc);
        r.dsz  = dif[REM_W-1:0];
        r.dctr = sum[REM_W-1:0];
        crop_axis = r;
    endfunction

    // Stage two: clamp, status and divider load.
    always_comb
    begin
        axx = crop_axis(pxl_reg, pxh_reg, win_l_reg, ext_x);
        axy = crop_axis(pyl_reg, pyh_reg, win_t_reg, ext_y);
        if ({1'b0, it1_reg.cls} >= cls_lim_reg)
            st2 = ST_CLASS;
        else if (!it1_reg.complete)
            st2 = ST_INCOMPLETE;
        else if (it1_reg.cx && axx.fail)
            st2 = ST_CROPPED;
        else if (it1_reg.cy && axy.fail)
            st2 = ST_CROPPED;
        else
            st2 = ST_KEPT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else
            dv_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        dit_reg[0]    <= '{st: st2, cls: it1_reg.cls, x: it1_reg.x, y: it1_reg.y,
                           w: it1_reg.w, h: it1_reg.h, cx: it1_reg.cx,
                           cy: it1_reg.cy, complete: it1_reg.complete};
        rem_reg[0][0] <= axx.dsz;
        rem_reg[0][1] <= axx.dctr;
        rem_reg[0][2] <= axy.dsz;
        rem_reg[0][3] <= axy.dctr;
        for (int l = 0; l < LANES; l++)
        begin
            quo_reg[0][l] <= '0;
        end
    end

    // Divider stages: one quotient bit per stage on every lane.
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic [REM_W:0]   trial [LANES];
        logic [REM_W-1:0] rem_next [LANES];
        logic [QUOT_W-1:0] quo_next [LANES];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[l] = {rem_reg[s][l], 1'b0};
                if (trial[l] >= {1'b0, divisor[l]})
                begin
                    rem_next[l] = REM_W'(trial[l] - {1'b0, divisor[l]});
                    quo_next[l] = {quo_reg[s][l][QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[l][REM_W-1:0];
                    quo_next[l] = {quo_reg[s][l][QUOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[s+1] <= 1'b0;
            else
                dv_reg[s+1] <= dv_reg[s];
        end

        always_ff @(posedge clk)
        begin
            dit_reg[s+1] <= dit_reg[s];
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[s+1][l] <= rem_next[l];
                quo_reg[s+1][l] <= quo_next[l];
            end
        end
    end

    // Aspect stage: pick cropped or original values and form cross products.
    always_comb
    begin
        itd = dit_reg[DIV_STAGES];
        nw  = itd.cx ? {1'b0, quo_reg[DIV_STAGES][0]} : itd.w;
        nx  = itd.cx ? {1'b0, quo_reg[DIV_STAGES][1]} : itd.x;
        nh  = itd.cy ? {1'b0, quo_reg[DIV_STAGES][2]} : itd.h;
        ny  = itd.cy ? {1'b0, quo_reg[DIV_STAGES][3]} : itd.y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= dv_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        itm_reg <= itd;
        nx_reg  <= nx;
        ny_reg  <= ny;
        nw_reg  <= nw;
        nh_reg  <= nh;
        pa_reg  <= nw * itd.h;
        pb_reg  <= itd.w * nh;
    end

    // Output stage: aspect verdict and orientation.
    always_comb
    begin
        st_o = itm_reg.st;
        if (st_o == ST_KEPT && (itm_reg.cx || itm_reg.cy))
        begin
            if (({2'b0, pa_reg} > {pb_reg, 2'b0}) || ({2'b0, pb_reg} > {pa_reg, 2'b0}))
                st_o = ST_ASPECT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        status    <= st_o;
        out_class <= itm_reg.cls;
        if (st_o != ST_KEPT)
        begin
            out_x <= '0;
            out_y <= '0;
            out_w <= '0;
            out_h <= '0;
        end
        else
        begin
            case (orient_reg)
                OR_LEFT:
                begin
                    out_w <= nh_reg;
                    out_h <= nw_reg;
                    out_x <= ny_reg;
                    out_y <= mirror(nx_reg);
                end
                OR_RIGHT:
                begin
                    out_w <= nh_reg;
                    out_h <= nw_reg;
                    out_x <= mirror(ny_reg);
                    out_y <= nx_reg;
                end
                OR_HFLIP:
                begin
                    out_w <= nw_reg;
                    out_h <= nh_reg;
                    out_x <= mirror(nx_reg);
                    out_y <= ny_reg;
                end
                OR_VFLIP:
                begin
                    out_w <= nw_reg;
                    out_h <= nh_reg;
                    out_x <= nx_reg;
                    out_y <= mirror(ny_reg);
                end
                OR_R180:
                begin
                    out_w <= nw_reg;
                    out_h <= nh_reg;
                    out_x <= mirror(nx_reg);
                    out_y <= mirror(ny_reg);
                end
                default:
                begin
                    out_w <= nw_reg;
                    out_h <= nh_reg;
                    out_x <= nx_reg;
                    out_y <= ny_reg;
                end
            endcase
        end
    end

endmodule
